[rtl/partition_count_table_macros.svh]
// Assertion macros used by the checker of the partition count table.
`ifndef PARTITION_COUNT_TABLE_MACROS_SVH
`define PARTITION_COUNT_TABLE_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted.
`define PCT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, quiet while reset is asserted.
`define PCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pct_pkg.sv]
// Package: widths, defaults and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package pct_pkg;

    localparam int MAX_ELEMENTS_DEF = 15;
    localparam int IN_W             = 4;
    localparam int VAL_W            = 31;
    localparam int S_TDATA_W        = 16;
    localparam int M_TDATA_W        = 64;

    typedef struct packed {
        logic load;
        logic row_step;
        logic sum_step;
        logic publish;
    } pct_cmd_t;

    typedef struct packed {
        logic reject;
        logic depth_zero;
        logic row_end;
        logic last_row;
        logic sum_end;
        logic out_free;
    } pct_sts_t;

endpackage
`default_nettype wire

[rtl/pct_ctrl.sv]
// Controller: sequences load, row building, row summing and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module pct_ctrl
    import pct_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire pct_sts_t sts,
    output pct_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_ROW   = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (sts.reject) begin
                    state_next = ST_DONE;
                end else if (sts.depth_zero) begin
                    state_next = ST_SUM;
                end else begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW: begin
                cmd.row_step = 1'b1;
                if (sts.row_end && sts.last_row) begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                cmd.sum_step = 1'b1;
                if (sts.sum_end) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the output register can take the result
                if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

[rtl/pct_dp.sv]
// Datapath: row buffer, multiply-add recurrence, row sum and output register.
`timescale 1ns / 1ps
`default_nettype none
module pct_dp
    import pct_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic [IN_W-1:0]      in_base_blocks,
    input  wire logic [IN_W-1:0]      in_depth,
    input  wire logic [IN_W-1:0]      in_sets,
    input  wire pct_cmd_t             cmd,
    output pct_sts_t                  sts,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [VAL_W-1:0]          out_entry_count,
    output logic [VAL_W-1:0]          out_row_total,
    output logic                      out_out_of_range
);

    localparam int IDX_W = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int FAC_W = IN_W + 1;
    localparam int PRD_W = FAC_W + VAL_W;
    localparam logic [FAC_W-1:0] MAX_SUM = FAC_W'(MAX_ELEMENTS);

    logic [IN_W-1:0]  base_blocks_reg;
    logic [IN_W-1:0]  depth_reg;
    logic [IN_W-1:0]  sets_reg;
    logic [IDX_W-1:0] row_reg;
    logic [IDX_W-1:0] j_reg;
    logic [VAL_W-1:0] prev_reg;
    logic [VAL_W-1:0] sum_reg;
    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] rd_reg;
    logic [VAL_W-1:0] row_mem [MAX_ELEMENTS];

    logic             m_tvalid_reg;
    logic [VAL_W-1:0] out_entry_reg;
    logic [VAL_W-1:0] out_total_reg;
    logic             out_err_reg;

    logic [VAL_W-1:0] rd_val;
    logic [VAL_W-1:0] old_val;
    logic [FAC_W-1:0] factor;
    logic [PRD_W-1:0] product;
    logic [VAL_W-1:0] new_val;
    logic [FAC_W-1:0] elem_sum;

    // rd_reg holds the buffer entry at j_reg during row and sum steps
    assign rd_val   = rd_reg;
    // entry past the end of the previous row reads as zero
    assign old_val  = (j_reg < row_reg) ? rd_val : '0;
    assign factor   = FAC_W'(base_blocks_reg) + FAC_W'(j_reg);
    assign product  = PRD_W'(factor) * PRD_W'(old_val);
    assign new_val  = prev_reg + product[VAL_W-1:0];
    assign elem_sum = FAC_W'(base_blocks_reg) + FAC_W'(depth_reg);

    assign sts.reject     = (base_blocks_reg == '0) || (elem_sum > MAX_SUM);
    assign sts.depth_zero = (depth_reg == '0);
    assign sts.row_end    = (j_reg == row_reg);
    assign sts.last_row   = (IN_W'(row_reg) == depth_reg);
    assign sts.sum_end    = (IN_W'(j_reg) == depth_reg);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            base_blocks_reg <= in_base_blocks;
            depth_reg       <= in_depth;
            sets_reg        <= in_sets;
            row_reg         <= IDX_W'(1);
            j_reg           <= '0;
            prev_reg        <= '0;
            sum_reg         <= '0;
            entry_reg       <= '0;
            row_mem[0]      <= VAL_W'(1);
            rd_reg          <= VAL_W'(1);
        end else if (cmd.row_step) begin
            row_mem[j_reg] <= new_val;
            if (sts.row_end) begin
                row_reg  <= row_reg + IDX_W'(1);
                j_reg    <= '0;
                prev_reg <= '0;
                rd_reg   <= row_mem[0];
            end else begin
                j_reg    <= j_reg + IDX_W'(1);
                prev_reg <= old_val;
                rd_reg   <= row_mem[j_reg + IDX_W'(1)];
            end
        end else if (cmd.sum_step) begin
            sum_reg <= sum_reg + rd_val;
            if (factor == FAC_W'(sets_reg)) begin
                entry_reg <= rd_val;
            end
            j_reg <= j_reg + IDX_W'(1);
            if (!sts.sum_end) begin
                rd_reg <= row_mem[j_reg + IDX_W'(1)];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.publish) begin
            out_entry_reg <= entry_reg;
            out_total_reg <= sum_reg;
            out_err_reg   <= sts.reject;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.publish) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid         = m_tvalid_reg;
    assign out_entry_count  = out_entry_reg;
    assign out_row_total    = out_total_reg;
    assign out_out_of_range = out_err_reg;

endmodule
`default_nettype wire

[rtl/partition_count_table.sv]
// Top level: r-Stirling partition count query engine on stream channels.
//
//   channel   dir   tdata fields (low bit up)                   tuser
//   s_        in    base_blocks[3:0] depth[7:4] sets[11:8] pad  -
//   m_        out   entry_count[30:0] row_total[61:31] pad      out_of_range
//
// A query builds rows 1..depth of the triangle in a row buffer, one entry per
// cycle through a shared multiply-add, then sums the final row one entry a cycle.
// One query is in flight; the next is accepted once the result sits in the output
// register, even while m_tready is low.
// Reset is synchronous on aresetn and empties the output register.
`timescale 1ns / 1ps
`default_nettype none
module partition_count_table
    import pct_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,  // base_blocks[3:0], depth[7:4], sets[11:8]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,  // entry_count[30:0], row_total[61:31]
    output logic                       m_tuser   // out_of_range[0]
);

    pct_cmd_t         cmd;
    pct_sts_t         sts;
    logic [VAL_W-1:0] entry_count;
    logic [VAL_W-1:0] row_total;
    logic             out_of_range;

    pct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    pct_dp #(
        .MAX_ELEMENTS (MAX_ELEMENTS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_base_blocks   (s_tdata[IN_W-1:0]),
        .in_depth         (s_tdata[2*IN_W-1:IN_W]),
        .in_sets          (s_tdata[3*IN_W-1:2*IN_W]),
        .cmd              (cmd),
        .sts              (sts),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_entry_count  (entry_count),
        .out_row_total    (row_total),
        .out_out_of_range (out_of_range)
    );

    assign m_tdata = {{(M_TDATA_W-2*VAL_W){1'b0}}, row_total, entry_count};
    assign m_tuser = out_of_range;

endmodule
`default_nettype wire

[rtl/pct_checker.sv]
// Port-level checker for the partition count table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "partition_count_table_macros.svh"
module pct_checker
    import pct_pkg::*;
(
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic [S_TDATA_W-1:0]  s_tdata,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [M_TDATA_W-1:0]  m_tdata,
    input wire logic                  m_tuser
);

    `PCT_ASSERT_NEXT(a_in_hold, s_tvalid && !s_tready, s_tvalid && $stable(s_tdata), "stalled input item changed")
    `PCT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled result item changed")
    `PCT_ASSERT_NOW(a_reject_zero, m_tvalid && m_tuser, m_tdata == '0, "rejected item carries nonzero counts")
    `PCT_ASSERT_NOW(a_entry_le_total, m_tvalid, m_tdata[30:0] <= m_tdata[61:31], "entry exceeds row total")
    `PCT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "second item taken while busy")

endmodule

bind partition_count_table pct_checker u_pct_checker (.*);
`default_nettype wire

[tb/sv/tb_partition_count_table.sv]
// Testbench for partition_count_table: random and directed queries against a row predictor.
`timescale 1ns / 1ps
module tb_partition_count_table;
    import pct_pkg::*;

    typedef struct {
        logic [IN_W-1:0] base_blocks;
        logic [IN_W-1:0] depth;
        logic [IN_W-1:0] sets;
    } count_query_t;

    typedef struct {
        logic [VAL_W-1:0] entry_count;
        logic [VAL_W-1:0] row_total;
        logic             out_of_range;
    } count_answer_t;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam longint unsigned MASK31 = 64'h7FFF_FFFF;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    count_query_t  pending_queries[$];
    count_answer_t expected_answers[$];
    count_query_t  offered_query;
    int            idle_pct = 23;
    int            error_count = 0;
    int            hold_off_requests = 0;
    int            hold_off_served = 0;
    int            hold_left = 0;

    partition_count_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #10_000_000;
        $display("partition_count_table test failed");
        $finish;
    end

    // Build the triangle row by row: T(i,j) = T(i-1,j-1) + j*T(i-1,j).
    function automatic count_answer_t predict_partition_counts(count_query_t q);
        longint unsigned row[0:15];
        longint unsigned nxt[0:15];
        longint unsigned total;
        int r, d, k, i, j;
        count_answer_t a;
        r = q.base_blocks;
        d = q.depth;
        k = q.sets;
        a.entry_count = '0;
        a.row_total = '0;
        a.out_of_range = 1'b0;
        if (r == 0 || r + d > MAX_ELEMENTS_DEF) begin
            a.out_of_range = 1'b1;
            return a;
        end
        for (j = 0; j < 16; j++) row[j] = 0;
        row[r] = 1;
        for (i = 1; i <= d; i++) begin
            for (j = 0; j < 16; j++) nxt[j] = 0;
            for (j = r; j <= r + i; j++) begin
                if (j == r + i)
                    nxt[j] = 1;
                else
                    nxt[j] = ((j > r ? row[j-1] : 0) + longint'(j) * row[j]) & MASK31;
            end
            row = nxt;
        end
        total = 0;
        for (j = r; j <= r + d; j++) total = (total + row[j]) & MASK31;
        if (k >= r && k <= r + d) a.entry_count = row[k][VAL_W-1:0];
        a.row_total = total[VAL_W-1:0];
        return a;
    endfunction

    function automatic count_query_t make_query(int r, int d, int k);
        count_query_t q;
        q.base_blocks = r[IN_W-1:0];
        q.depth = d[IN_W-1:0];
        q.sets = k[IN_W-1:0];
        return q;
    endfunction

    // Mostly well-formed queries with shallow depth; some noise over the full field range.
    function automatic count_query_t random_query();
        int r, d, k, dmax;
        if ($urandom_range(99) < 25)
            return make_query($urandom_range(15), $urandom_range(15), $urandom_range(15));
        r = $urandom_range(1, 15);
        dmax = MAX_ELEMENTS_DEF - r;
        if ($urandom_range(9) == 0)
            d = $urandom_range(0, dmax);
        else
            d = $urandom_range(0, dmax < 5 ? dmax : 5);
        if ($urandom_range(99) < 80)
            k = $urandom_range(r, r + d);
        else
            k = $urandom_range(15);
        return make_query(r, d, k);
    endfunction

    always @(posedge aclk) begin : query_driver
        count_query_t next_query;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_answers.push_back(predict_partition_counts(offered_query));
            if (pending_queries.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_query = pending_queries.pop_front();
                offered_query <= next_query;
                s_tdata <= {4'b0, next_query.sets, next_query.depth, next_query.base_blocks};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin : answer_monitor
        count_answer_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_answers.size() == 0) begin
                    $error("result item with no query outstanding");
                    error_count++;
                end else begin
                    want = expected_answers.pop_front();
                    if (m_tdata[30:0] !== want.entry_count) begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, m_tdata[30:0]);
                        error_count++;
                    end
                    if (m_tdata[61:31] !== want.row_total) begin
                        $error("row_total mismatch: expected %0d, actual %0d",
                               want.row_total, m_tdata[61:31]);
                        error_count++;
                    end
                    if (m_tuser !== want.out_of_range) begin
                        $error("out_of_range mismatch: expected %0d, actual %0d",
                               want.out_of_range, m_tuser);
                        error_count++;
                    end
                end
            end
            // Hold off long enough for the block to back up and stall its input.
            if (hold_off_served != hold_off_requests) begin
                hold_off_served <= hold_off_requests;
                hold_left <= HOLD_OFF_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= idle_pct);
            end
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        pending_queries.push_back(make_query(1, 0, 1));
        pending_queries.push_back(make_query(1, 14, 1));
        pending_queries.push_back(make_query(1, 14, 8));
        pending_queries.push_back(make_query(1, 14, 15));
        pending_queries.push_back(make_query(1, 14, 0));
        pending_queries.push_back(make_query(1, 14, 8));
        pending_queries.push_back(make_query(15, 0, 15));
        pending_queries.push_back(make_query(15, 0, 0));
        pending_queries.push_back(make_query(15, 0, 14));
        pending_queries.push_back(make_query(0, 0, 0));
        pending_queries.push_back(make_query(0, 14, 15));
        pending_queries.push_back(make_query(15, 15, 15));
        pending_queries.push_back(make_query(8, 8, 10));
        pending_queries.push_back(make_query(1, 15, 0));
        pending_queries.push_back(make_query(7, 8, 15));
        pending_queries.push_back(make_query(7, 8, 7));
        pending_queries.push_back(make_query(7, 8, 6));
        pending_queries.push_back(make_query(3, 5, 9));
        pending_queries.push_back(make_query(2, 13, 15));
        pending_queries.push_back(make_query(2, 13, 7));
        pending_queries.push_back(make_query(10, 5, 12));

        // Wait until every directed answer is back before queueing random queries.
        while (pending_queries.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(negedge aclk);

        idle_pct = 0;
        repeat (300) pending_queries.push_back(random_query());
        while (pending_queries.size() != 0) @(negedge aclk);

        idle_pct = 23;
        hold_off_requests++;
        repeat (1150) pending_queries.push_back(random_query());

        while (pending_queries.size() != 0 || s_tvalid || expected_answers.size() != 0)
            @(negedge aclk);
        repeat (150) @(negedge aclk);

        if (error_count == 0)
            $display("partition_count_table test passed");
        else
            $display("partition_count_table test failed");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/pct_pkg.sv
rtl/pct_ctrl.sv
rtl/pct_dp.sv
rtl/partition_count_table.sv
rtl/pct_checker.sv
tb/sv/tb_partition_count_table.sv
